// ===== rtl/dnsqx_pkg.sv =====
package dnsqx_pkg;

	// Parser phases.
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_LEN    = 3'd1;
	localparam logic [2:0] PH_LABEL  = 3'd2;
	localparam logic [2:0] PH_TYPE   = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	localparam int HDR_BYTES     = 12;
	localparam int MAX_LABEL_LEN = 63;
	localparam logic [7:0] DOT_CHAR = 8'd46;
	localparam logic [15:0] PORT_RESET = 16'd53;

	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [6:0]  name_length;
		logic        query_type_valid;
		logic [15:0] query_type;
		logic [15:0] transaction_id;
		logic [7:0]  name_char;
	} res_data_t;

	typedef struct packed {
		logic        kind;
		logic        last_of_run;
		res_data_t   data;
	} res_t;

	// Results caused by one payload byte: at most a character and a summary.
	typedef struct packed {
		logic char_valid;
		res_t char_res;
		logic sum_valid;
		res_t sum_res;
	} res_pair_t;

endpackage

// ===== rtl/dnsqx_parse.sv =====
module dnsqx_parse #(
	parameter int NAME_LEN   = 128,
	parameter int MAX_LABELS = 32,
	parameter int MSG_LIMIT  = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [7:0]            payload_byte,
	input  logic [15:0]           dest_port,
	input  logic                  end_of_message,
	input  logic [15:0]           match_port,
	output dnsqx_pkg::res_pair_t  results
);
	import dnsqx_pkg::*;

	localparam int OW = $clog2(MSG_LIMIT + 1);
	localparam int CW = $clog2(NAME_LEN);
	localparam int LW = $clog2(MAX_LABELS + 1);

	logic [OW-1:0] offset_q, offset_n;
	logic [2:0]    phase_q, phase_n;
	logic [5:0]    left_q, left_n, left_dec;
	logic [LW-1:0] labels_q, labels_n;
	logic [CW-1:0] chars_q, chars_n;
	logic [15:0]   id_q, id_n;
	logic [15:0]   type_q, type_n;
	logic [1:0]    seen_q, seen_n;
	logic          kept_q, kept_n;

	logic          emit;
	logic [7:0]    emit_char;
	logic          char_ok;
	logic [15:0]   chars_ext;
	logic          type_ok;

	always_comb begin
		offset_n  = offset_q;
		phase_n   = phase_q;
		left_n    = left_q;
		labels_n  = labels_q;
		id_n      = id_q;
		type_n    = type_q;
		seen_n    = seen_q;
		kept_n    = (offset_q == '0) ? (dest_port == match_port) : kept_q;
		emit      = 1'b0;
		emit_char = payload_byte;
		left_dec  = left_q;

		if (offset_q < OW'(MSG_LIMIT)) begin
			case (phase_q)
				PH_HEADER: begin
					if (offset_q == OW'(0)) begin
						id_n = {payload_byte, 8'd0};
					end else if (offset_q == OW'(1)) begin
						id_n = id_q | {8'd0, payload_byte};
					end else if (offset_q == OW'(2) && payload_byte[7]) begin
						kept_n = 1'b0;
					end
					if (offset_q == OW'(HDR_BYTES - 1)) begin
						phase_n = PH_LEN;
					end
				end
				PH_LEN: begin
					if (payload_byte == 8'd0 || payload_byte > 8'(MAX_LABEL_LEN)) begin
						phase_n = PH_TYPE;
					end else begin
						labels_n  = labels_q + 1'b1;
						emit      = (chars_q != '0);
						emit_char = DOT_CHAR;
						left_n    = payload_byte[5:0];
						phase_n   = PH_LABEL;
					end
				end
				PH_LABEL: begin
					emit = 1'b1;
					if (left_q != 6'd0) begin
						left_dec = left_q - 1'b1;
					end
					left_n = left_dec;
					if (left_dec == 6'd0) begin
						phase_n = (labels_q >= LW'(MAX_LABELS)) ? PH_TYPE : PH_LEN;
					end
				end
				PH_TYPE: begin
					type_n = {type_q[7:0], payload_byte};
					seen_n = seen_q + 1'b1;
					if (seen_n >= 2'd2) begin
						phase_n = PH_DONE;
					end
				end
				default: begin
				end
			endcase
			offset_n = offset_q + 1'b1;
		end

		// Characters past the name capacity are dropped without a trace.
		char_ok = emit && (chars_q < CW'(NAME_LEN - 1));
		chars_n = char_ok ? chars_q + 1'b1 : chars_q;
	end

	assign chars_ext = 16'(chars_n);
	assign type_ok   = (seen_n >= 2'd2);

	always_comb begin
		results.char_valid                          = char_ok && kept_n;
		results.char_res.kind                       = KIND_CHAR;
		results.char_res.last_of_run                = !(end_of_message && kept_n);
		results.char_res.data.name_char             = emit_char;
		results.char_res.data.transaction_id        = id_n;
		results.char_res.data.query_type            = 16'd0;
		results.char_res.data.query_type_valid      = 1'b0;
		results.char_res.data.name_length           = chars_ext[6:0];

		results.sum_valid                           = end_of_message && kept_n;
		results.sum_res.kind                        = KIND_SUMMARY;
		results.sum_res.last_of_run                 = 1'b1;
		results.sum_res.data.name_char              = 8'd0;
		results.sum_res.data.transaction_id         = id_n;
		results.sum_res.data.query_type             = type_ok ? type_n : 16'd0;
		results.sum_res.data.query_type_valid       = type_ok;
		results.sum_res.data.name_length            = chars_ext[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			phase_q  <= PH_HEADER;
			left_q   <= '0;
			labels_q <= '0;
			chars_q  <= '0;
			id_q     <= '0;
			type_q   <= '0;
			seen_q   <= '0;
			kept_q   <= 1'b0;
		end else if (advance) begin
			if (end_of_message) begin
				offset_q <= '0;
				phase_q  <= PH_HEADER;
				left_q   <= '0;
				labels_q <= '0;
				chars_q  <= '0;
				id_q     <= '0;
				type_q   <= '0;
				seen_q   <= '0;
				kept_q   <= 1'b0;
			end else begin
				offset_q <= offset_n;
				phase_q  <= phase_n;
				left_q   <= left_n;
				labels_q <= labels_n;
				chars_q  <= chars_n;
				id_q     <= id_n;
				type_q   <= type_n;
				seen_q   <= seen_n;
				kept_q   <= kept_n;
			end
		end
	end

endmodule

// ===== rtl/dnsqx_outbuf.sv =====
module dnsqx_outbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  write,
	input  dnsqx_pkg::res_pair_t  results,
	output logic                  free,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [47:0]           m_axis_tdata,  // name_char, transaction_id, query_type,
	                                              // query_type_valid, name_length
	output logic                  m_axis_tuser,  // kind
	output logic                  m_axis_tlast   // last_of_run
);
	import dnsqx_pkg::*;

	logic a_valid_q, b_valid_q;
	res_t a_q, b_q;
	res_t head;
	logic take;

	assign head          = a_valid_q ? a_q : b_q;
	assign m_axis_tvalid = a_valid_q || b_valid_q;
	assign m_axis_tdata  = head.data;
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last_of_run;
	assign take          = m_axis_tvalid && m_axis_tready;

	// The buffer can take a new pair once at most one request is left and it leaves now.
	assign free = !(a_valid_q || b_valid_q) || ((a_valid_q ^ b_valid_q) && m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q <= 1'b0;
			b_valid_q <= 1'b0;
		end else if (write) begin
			a_valid_q <= results.char_valid;
			b_valid_q <= results.sum_valid;
		end else if (take) begin
			if (a_valid_q) begin
				a_valid_q <= 1'b0;
			end else begin
				b_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (write) begin
			a_q <= results.char_res;
			b_q <= results.sum_res;
		end
	end

endmodule

// ===== rtl/dns_query_name_extractor_core.sv =====
// DNS query name extractor: takes one UDP payload byte per request on the slave
// stream and returns the dotted query name one character per request, followed
// on the last byte of a kept message by a summary with transaction ID, qtype and
// name length. Responses and messages whose destination port differs from
// match_port give no output. A byte is accepted every cycle while the output
// buffer is free; a byte is registered, then its results in the output buffer.
// A last byte that also yields a name character gives two output requests and
// holds the input until the first has left. match_port resets to 53 and is to be
// written only while the block is idle; the block itself does not enforce this.
module dns_query_name_extractor_core #(
	parameter int NAME_LEN   = 128,
	parameter int MAX_LABELS = 32,
	parameter int MSG_LIMIT  = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // payload_byte, dest_port
	input  logic        s_axis_tlast,   // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // name_char, transaction_id, query_type,
	                                    // query_type_valid, name_length
	output logic [0:0]  m_axis_tuser,   // kind
	output logic        m_axis_tlast    // last_of_run
);
	import dnsqx_pkg::*;

	logic [15:0] match_port_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [15:0] port_s1;
	logic        last_s1;
	logic        free;
	logic        advance;
	res_pair_t   results;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_port_q <= PORT_RESET;
		end else if (cfg_valid) begin
			match_port_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata[7:0];
			port_s1 <= s_axis_tdata[23:8];
			last_s1 <= s_axis_tlast;
		end
	end

	dnsqx_parse #(
		.NAME_LEN   (NAME_LEN),
		.MAX_LABELS (MAX_LABELS),
		.MSG_LIMIT  (MSG_LIMIT)
	) u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.payload_byte   (byte_s1),
		.dest_port      (port_s1),
		.end_of_message (last_s1),
		.match_port     (match_port_q),
		.results        (results)
	);

	dnsqx_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.write         (advance),
		.results       (results),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser[0]),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== tb/dns_query_name_extractor_checker.sv =====
module dns_query_name_extractor_checker #(
	parameter int NAME_LEN   = 128,
	parameter int MAX_LABELS = 32,
	parameter int MSG_LIMIT  = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // payload_byte, dest_port
	input  logic        s_axis_tlast,   // end_of_message
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,   // name_char, transaction_id, query_type,
	                                    // query_type_valid, name_length
	input  logic [0:0]  m_axis_tuser,   // kind
	input  logic        m_axis_tlast,   // last_of_run
	output int          mismatches,
	output int          results_waiting,
	output int          chars_seen,
	output int          summaries_seen
);
	import dnsqx_pkg::*;

	logic [15:0] query_port;
	logic [9:0]  offset;
	logic [2:0]  phase;
	logic [5:0]  label_left;
	logic [5:0]  label_count;
	logic [7:0]  name_chars;
	logic [15:0] txn_id;
	logic [15:0] qtype;
	logic [1:0]  qtype_bytes;
	logic        kept;
	res_t        expected_results[$];

	function automatic void clear_message();
		offset      = '0;
		phase       = PH_HEADER;
		label_left  = '0;
		label_count = '0;
		name_chars  = '0;
		txn_id      = '0;
		qtype       = '0;
		qtype_bytes = '0;
		kept        = 1'b0;
	endfunction

	// Advances the parser by one payload byte and queues the results it causes.
	function automatic void predict_byte(logic [7:0] b, logic [15:0] port, logic eom);
		logic       has_char;
		logic [7:0] ch;
		res_t       r;
		has_char = 1'b0;
		ch = '0;
		if (offset == 0)
			kept = (port == query_port);
		if (offset < MSG_LIMIT) begin
			case (phase)
				PH_HEADER: begin
					if (offset == 0)
						txn_id = {b, 8'h00};
					else if (offset == 1)
						txn_id[7:0] = b;
					else if (offset == 2 && b[7])
						kept = 1'b0;
					if (offset == HDR_BYTES - 1)
						phase = PH_LEN;
				end
				PH_LEN: begin
					// A zero length or anything that looks like a pointer ends the name.
					if (b == 0 || b > MAX_LABEL_LEN) begin
						phase = PH_TYPE;
					end else begin
						label_count++;
						has_char = (name_chars != 0);
						ch = DOT_CHAR;
						label_left = b[5:0];
						phase = PH_LABEL;
					end
				end
				PH_LABEL: begin
					has_char = 1'b1;
					ch = b;
					if (label_left > 0)
						label_left--;
					if (label_left == 0)
						phase = (label_count >= MAX_LABELS) ? PH_TYPE : PH_LEN;
				end
				PH_TYPE: begin
					qtype = {qtype[7:0], b};
					qtype_bytes++;
					if (qtype_bytes >= 2)
						phase = PH_DONE;
				end
				default: ;
			endcase
			offset++;
		end

		// Once the name buffer is full, further characters vanish without a result.
		if (has_char && name_chars < NAME_LEN - 1) begin
			name_chars++;
			if (kept) begin
				r = '0;
				r.kind = KIND_CHAR;
				r.last_of_run = !eom;
				r.data.name_char = ch;
				r.data.transaction_id = txn_id;
				r.data.name_length = name_chars[6:0];
				expected_results.push_back(r);
			end
		end

		if (eom) begin
			if (kept) begin
				r = '0;
				r.kind = KIND_SUMMARY;
				r.last_of_run = 1'b1;
				r.data.transaction_id = txn_id;
				r.data.query_type_valid = (qtype_bytes >= 2);
				r.data.query_type = r.data.query_type_valid ? qtype : 16'h0000;
				r.data.name_length = name_chars[6:0];
				expected_results.push_back(r);
			end
			clear_message();
		end
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		res_data_t got;
		res_t      want;
		if (!arst_n) begin
			query_port = PORT_RESET;
			clear_message();
			expected_results.delete();
			mismatches = 0;
			chars_seen = 0;
			summaries_seen = 0;
			results_waiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				query_port = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				predict_byte(s_axis_tdata[7:0], s_axis_tdata[23:8], s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got = res_data_t'(m_axis_tdata);
				if (m_axis_tuser[0] == KIND_SUMMARY)
					summaries_seen++;
				else
					chars_seen++;
				if (expected_results.size() == 0) begin
					$error("result with none expected: kind %0d char %0h id %0h",
						m_axis_tuser[0], got.name_char, got.transaction_id);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("kind", want.kind, m_axis_tuser[0]);
					check_field("name_char", want.data.name_char, got.name_char);
					check_field("transaction_id", want.data.transaction_id, got.transaction_id);
					check_field("query_type", want.data.query_type, got.query_type);
					check_field("query_type_valid", want.data.query_type_valid,
						got.query_type_valid);
					check_field("name_length", want.data.name_length, got.name_length);
					check_field("last_of_run", want.last_of_run, m_axis_tlast);
				end
			end
			results_waiting <= expected_results.size();
		end
	end

endmodule

// ===== tb/dns_query_name_extractor_core_tb.sv =====
module dns_query_name_extractor_core_tb;
	import dnsqx_pkg::*;

	localparam int NAME_LEN     = 128;
	localparam int MAX_LABELS   = 32;
	localparam int MSG_LIMIT    = 512;
	localparam int RANDOM_BYTES = 300;
	localparam int CALM_BYTES   = 50;
	localparam int LONG_HOLD    = 200;
	localparam int QUIET_LIMIT  = 2000;
	localparam int SETTLE       = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int          mismatches;
	int          results_waiting;
	int          chars_seen;
	int          summaries_seen;
	int          quiet_cycles = 0;
	int          bytes_sent = 0;
	int          messages_sent = 0;
	int          port_writes = 0;
	logic        sender_gaps = 1'b1;
	logic        receiver_gaps = 1'b1;
	logic        hold_req = 1'b0;
	logic [15:0] query_port = PORT_RESET;
	logic [7:0]  msg_buf[$];

	dns_query_name_extractor_core #(
		.NAME_LEN  (NAME_LEN),
		.MAX_LABELS(MAX_LABELS),
		.MSG_LIMIT (MSG_LIMIT)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	dns_query_name_extractor_checker #(
		.NAME_LEN  (NAME_LEN),
		.MAX_LABELS(MAX_LABELS),
		.MSG_LIMIT (MSG_LIMIT)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast),
		.mismatches     (mismatches),
		.results_waiting(results_waiting),
		.chars_seen     (chars_seen),
		.summaries_seen (summaries_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Output side: short random stalls, plus one long hold when asked for.
	always begin
		@(posedge clk);
		if (hold_req) begin
			m_axis_tready <= 1'b0;
			repeat (LONG_HOLD) @(posedge clk);
			hold_req = 1'b0;
		end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		m_axis_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("dns_query_name_extractor_core_tb NOT OK");
			$finish;
		end
	end

	// One request per payload byte; valid stays high across back-to-back requests.
	task automatic send_byte(input logic [7:0] b, input logic [15:0] port, input logic eom);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {port, b};
		s_axis_tlast  <= eom;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	// The port only matters on the first byte, so the rest carry random ports.
	task automatic send_message(input logic [15:0] port);
		foreach (msg_buf[i])
			send_byte(msg_buf[i], (i == 0) ? port : 16'($urandom), i == msg_buf.size() - 1);
		messages_sent++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_waiting != 0)
			@(posedge clk);
		// Dropped messages leave nothing to wait for, so give the pipeline time to drain.
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_port(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		query_port = value;
		port_writes++;
	endtask

	function automatic void start_header(input logic [15:0] id, input logic response);
		msg_buf.delete();
		msg_buf.push_back(id[15:8]);
		msg_buf.push_back(id[7:0]);
		msg_buf.push_back({response, 7'($urandom)});
		repeat (HDR_BYTES - 3) msg_buf.push_back(8'($urandom));
	endfunction

	function automatic void add_label(input int len);
		msg_buf.push_back(8'(len));
		repeat (len) msg_buf.push_back(8'($urandom));
	endfunction

	initial begin : stimulus
		logic [15:0] port_plan[4];
		logic [15:0] port;
		int          random_sent;
		int          phase_end;
		int          cut;
		int          pick;
		port_plan = '{16'h0000, 16'hFFFF, 16'($urandom), PORT_RESET};
		random_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A one-byte message yields only a summary with the high ID byte.
		msg_buf = {8'hA5};
		send_message(PORT_RESET);
		// Ordinary query with bytes after the qtype.
		start_header(16'h1234, 1'b0);
		add_label(3);
		add_label(2);
		msg_buf.push_back(8'h00);
		msg_buf.push_back(8'h00);
		msg_buf.push_back(8'h01);
		msg_buf.push_back(8'hFF);
		send_message(PORT_RESET);
		// A response is dropped.
		start_header(16'hFFFF, 1'b1);
		add_label(4);
		msg_buf.push_back(8'h00);
		send_message(PORT_RESET);
		// So is a message to another port.
		start_header(16'h0000, 1'b0);
		add_label(4);
		msg_buf.push_back(8'h00);
		send_message(16'd54);
		// Extreme characters, then a compression pointer ends the name.
		start_header(16'h8001, 1'b0);
		msg_buf.push_back(8'd2);
		msg_buf.push_back(8'h00);
		msg_buf.push_back(8'hFF);
		msg_buf.push_back(8'hC0);
		msg_buf.push_back(8'hFF);
		msg_buf.push_back(8'hFF);
		send_message(PORT_RESET);
		// A length of 64 is too long for a label.
		start_header(16'h4242, 1'b0);
		add_label(1);
		msg_buf.push_back(8'd64);
		msg_buf.push_back(8'h12);
		msg_buf.push_back(8'h34);
		send_message(PORT_RESET);
		// More labels than the limit; the qtype is taken right after the last allowed one.
		start_header(16'h0F0F, 1'b0);
		repeat (MAX_LABELS + 1) add_label(1);
		msg_buf.push_back(8'h00);
		msg_buf.push_back(8'h1C);
		send_message(PORT_RESET);
		// The name outgrows the buffer and the message runs past the parse limit
		// before its qtype.
		start_header(16'hABCD, 1'b0);
		repeat (8) add_label(63);
		msg_buf.push_back(8'h00);
		msg_buf.push_back(8'h00);
		msg_buf.push_back(8'h01);
		send_message(PORT_RESET);
		// Message cut off inside a label, and one that is only a header.
		start_header(16'h5A5A, 1'b0);
		msg_buf.push_back(8'd5);
		msg_buf.push_back(8'h61);
		msg_buf.push_back(8'h62);
		send_message(PORT_RESET);
		start_header(16'hC3C3, 1'b0);
		send_message(PORT_RESET);

		for (int p = 0; p < 4; p++) begin
			wait_idle();
			write_port(port_plan[p]);
			// Stall the output for a long stretch while requests keep coming.
			if (p == 1)
				hold_req = 1'b1;
			phase_end = (p + 1) * RANDOM_BYTES / 4;
			while (random_sent < phase_end) begin
				pick = $urandom_range(0, 9);
				if (pick < 8) begin
					start_header(16'($urandom), $urandom_range(0, 9) == 0);
					repeat ($urandom_range(0, 4))
						add_label(($urandom_range(0, 15) == 0) ? 63 : $urandom_range(1, 8));
					if ($urandom_range(0, 5) == 0)
						msg_buf.push_back(8'($urandom_range(64, 255)));
					else
						msg_buf.push_back(8'h00);
					repeat ($urandom_range(2, 5)) msg_buf.push_back(8'($urandom));
					if ($urandom_range(0, 7) == 0) begin
						cut = $urandom_range(1, msg_buf.size());
						msg_buf = msg_buf[0:cut - 1];
					end
					port = ($urandom_range(0, 9) == 0) ? 16'($urandom) : query_port;
				end else begin
					msg_buf.delete();
					repeat ($urandom_range(1, 40)) msg_buf.push_back(8'($urandom));
					port = $urandom_range(0, 1) ? 16'($urandom) : query_port;
				end
				if (p == 3 && random_sent >= RANDOM_BYTES - CALM_BYTES) begin
					sender_gaps = 1'b0;
					receiver_gaps = 1'b0;
				end
				send_message(port);
				random_sent += msg_buf.size();
			end
		end
		wait_idle();

		$display("Sent %0d payload bytes in %0d messages under %0d match_port settings.",
			bytes_sent, messages_sent, port_writes + 1);
		$display("Checked %0d name characters and %0d message summaries.",
			chars_seen, summaries_seen);
		if (mismatches == 0)
			$display("dns_query_name_extractor_core_tb OK");
		else
			$display("dns_query_name_extractor_core_tb NOT OK");
		$finish;
	end

endmodule

// ===== dns_query_name_extractor_core.f =====
rtl/dnsqx_pkg.sv
rtl/dnsqx_parse.sv
rtl/dnsqx_outbuf.sv
rtl/dns_query_name_extractor_core.sv
tb/dns_query_name_extractor_checker.sv
tb/dns_query_name_extractor_core_tb.sv
